// ===== rtl/core/mutex_bank_with_fifo_handoff_assert.svh =====
// ----------------------------------------------------------------------------
// mutex bank assertion macros
// shared concurrent assertion forms, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef MUTEX_BANK_WITH_FIFO_HANDOFF_ASSERT_SVH
`define MUTEX_BANK_WITH_FIFO_HANDOFF_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MBFH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MBFH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mbfh_pkg.sv =====
// ----------------------------------------------------------------------------
// mbfh_pkg
// shared codes and controller/datapath interface types for the mutex bank
// ----------------------------------------------------------------------------
`default_nettype none

package mbfh_pkg;

  localparam int unsigned MutexIdW = 3;
  localparam int unsigned StatusW  = 3;

  // request kinds
  localparam logic MODE_LOCK   = 1'b0;
  localparam logic MODE_UNLOCK = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] ST_ACQUIRED   = 3'd0;
  localparam logic [StatusW-1:0] ST_RELOCK     = 3'd1;
  localparam logic [StatusW-1:0] ST_QUEUED     = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL       = 3'd3;
  localparam logic [StatusW-1:0] ST_RELEASED   = 3'd4;
  localparam logic [StatusW-1:0] ST_HANDOFF    = 3'd5;
  localparam logic [StatusW-1:0] ST_NOT_LOCKED = 3'd6;
  localparam logic [StatusW-1:0] ST_NOT_OWNER  = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic capture;  // take request beat, read mutex record
    logic commit;   // apply decision, load result
    logic pop;      // read oldest waiter
    logic wake;     // hand mutex to popped waiter, load result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic handoff;  // owner unlock with waiters present
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/mutex_bank_with_fifo_handoff.sv =====
// ----------------------------------------------------------------------------
// mutex_bank_with_fifo_handoff
// bank of mutexes, each with an owner and a fifo of waiting task ids
// ----------------------------------------------------------------------------
// each request beat (lock or unlock of one mutex by one task) yields exactly
// one result beat. the accepting edge reads the mutex record memory (owner,
// queue pointers, count) into registers; the evaluation step then decides,
// writes the record back and loads the result register, which offers the
// result beat, and the sequencer returns to idle for the next request. an
// unlock that hands the mutex to a waiter adds a waiter-read step, since the
// waiter memory is read at the head pointer that only arrives with the
// record. one request is in flight at a time; the result sits in an output
// register, and a stalled result beat holds the next request in evaluation
// or waiter read until the register frees. no clearing pass follows reset:
// held bits reset in flip-flops and a record is rewritten whenever its mutex
// is taken from free. mutex ids beyond the bank wrap modulo NUM_MUTEX.
// ----------------------------------------------------------------------------
`default_nettype none

module mutex_bank_with_fifo_handoff #(
  parameter int unsigned NUM_MUTEX  = 8,
  parameter int unsigned WAIT_DEPTH = 16,
  parameter int unsigned NUM_TASKS  = 256
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // request channel
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              mode_i,
  input  wire  [mbfh_pkg::MutexIdW-1:0]    mutex_id_i,
  input  wire  [$clog2(NUM_TASKS)-1:0]     task_id_i,
  // result channel
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [mbfh_pkg::StatusW-1:0]     status_o,
  output logic [$clog2(NUM_TASKS)-1:0]     woken_task_o,
  output logic                             woken_valid_o
);

  // command and status between sequencer and datapath
  mbfh_pkg::cmd_t cmd;
  mbfh_pkg::sts_t sts;

  // sequencer: handshakes and the evaluate / waiter-read steps
  mbfh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: record and waiter memories, decision, result register
  mbfh_dp #(
    .NUM_MUTEX  (NUM_MUTEX),
    .WAIT_DEPTH (WAIT_DEPTH),
    .NUM_TASKS  (NUM_TASKS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_i),
    .mutex_id_i    (mutex_id_i),
    .task_id_i     (task_id_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .woken_task_o  (woken_task_o),
    .woken_valid_o (woken_valid_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/mbfh_dp.sv =====
// ----------------------------------------------------------------------------
// mbfh_dp
// request registers, per-mutex record memory, waiter memory and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mbfh_dp #(
  parameter int unsigned NUM_MUTEX  = 8,
  parameter int unsigned WAIT_DEPTH = 16,
  parameter int unsigned NUM_TASKS  = 256
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                mode_i,
  input  wire  [mbfh_pkg::MutexIdW-1:0]      mutex_id_i,
  input  wire  [$clog2(NUM_TASKS)-1:0]       task_id_i,
  input  wire  mbfh_pkg::cmd_t               cmd_i,
  output mbfh_pkg::sts_t                     sts_o,
  output logic [mbfh_pkg::StatusW-1:0]       status_o,
  output logic [$clog2(NUM_TASKS)-1:0]       woken_task_o,
  output logic                               woken_valid_o
);

  localparam int unsigned TaskW = $clog2(NUM_TASKS);
  localparam int unsigned MidW  = (NUM_MUTEX > 1) ? $clog2(NUM_MUTEX) : 1;
  localparam int unsigned PtrW  = $clog2(WAIT_DEPTH);
  localparam int unsigned CntW  = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned Depth = NUM_MUTEX * WAIT_DEPTH;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [8:0]  NumMutexV = 9'(NUM_MUTEX);

  // mutex id folded into the bank, narrow repeated subtract
  function automatic logic [MidW-1:0] bank_index(input logic [mbfh_pkg::MutexIdW-1:0] id);
    logic [8:0] v;
    v = 9'(id);
    for (int i = 0; i < 8; i++) begin
      if (v >= NumMutexV) begin
        v = v - NumMutexV;
      end
    end
    return v[MidW-1:0];
  endfunction

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(WAIT_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  function automatic logic [AddrW-1:0] slot_addr(input logic [MidW-1:0] m,
                                                 input logic [PtrW-1:0] p);
    return AddrW'(m) * AddrW'(WAIT_DEPTH) + AddrW'(p);
  endfunction

  // request
  logic             unlock_q;
  logic [MidW-1:0]  mid_q;
  logic [TaskW-1:0] task_q;
  logic [MidW-1:0]  in_mid;

  // per-mutex record, valid only while held
  logic [TaskW-1:0] own_mem  [NUM_MUTEX];
  logic [PtrW-1:0]  head_mem [NUM_MUTEX];
  logic [PtrW-1:0]  tail_mem [NUM_MUTEX];
  logic [CntW-1:0]  cnt_mem  [NUM_MUTEX];
  logic [TaskW-1:0] own_q;
  logic [PtrW-1:0]  head_q;
  logic [PtrW-1:0]  tail_q;
  logic [CntW-1:0]  cnt_q;
  logic [NUM_MUTEX-1:0] held_q;

  // waiter queues, all mutexes in one store
  logic [TaskW-1:0] wait_mem [Depth];
  logic [TaskW-1:0] wait_q;

  // decision
  logic                          held_bit;
  logic                          is_owner;
  logic [mbfh_pkg::StatusW-1:0]  dec_status;
  logic                          rec_we;
  logic                          wait_we;
  logic                          held_we;
  logic                          held_val;
  logic                          handoff;
  logic [TaskW-1:0]              new_own;
  logic [PtrW-1:0]               new_head;
  logic [PtrW-1:0]               new_tail;
  logic [CntW-1:0]               new_cnt;
  logic                          rec_wr;
  logic [TaskW-1:0]              wr_own;
  logic [PtrW-1:0]               wr_head;
  logic [CntW-1:0]               wr_cnt;

  // result
  logic [mbfh_pkg::StatusW-1:0]  status_q;
  logic [TaskW-1:0]              woken_task_q;
  logic                          woken_valid_q;

  assign in_mid   = bank_index(mutex_id_i);
  assign held_bit = held_q[mid_q];
  assign is_owner = (own_q == task_q);

  always_comb begin
    dec_status = mbfh_pkg::ST_ACQUIRED;
    rec_we     = 1'b0;
    wait_we    = 1'b0;
    held_we    = 1'b0;
    held_val   = 1'b0;
    handoff    = 1'b0;
    new_own    = own_q;
    new_head   = head_q;
    new_tail   = tail_q;
    new_cnt    = cnt_q;
    if (!unlock_q) begin
      priority if (!held_bit) begin
        dec_status = mbfh_pkg::ST_ACQUIRED;
        rec_we     = 1'b1;
        held_we    = 1'b1;
        held_val   = 1'b1;
        new_own    = task_q;
        new_head   = '0;
        new_tail   = '0;
        new_cnt    = '0;
      end else if (is_owner) begin
        dec_status = mbfh_pkg::ST_RELOCK;
      end else if (cnt_q == CntW'(WAIT_DEPTH)) begin
        dec_status = mbfh_pkg::ST_FULL;
      end else begin
        dec_status = mbfh_pkg::ST_QUEUED;
        rec_we     = 1'b1;
        wait_we    = 1'b1;
        new_tail   = ptr_next(tail_q);
        new_cnt    = cnt_q + CntW'(1);
      end
    end else begin
      priority if (!held_bit) begin
        dec_status = mbfh_pkg::ST_NOT_LOCKED;
      end else if (!is_owner) begin
        dec_status = mbfh_pkg::ST_NOT_OWNER;
      end else if (cnt_q == '0) begin
        dec_status = mbfh_pkg::ST_RELEASED;
        held_we    = 1'b1;
        held_val   = 1'b0;
      end else begin
        dec_status = mbfh_pkg::ST_HANDOFF;
        handoff    = 1'b1;
      end
    end
  end

  assign sts_o.handoff = handoff;

  // one record write port, shared by commit and wake
  assign rec_wr  = (cmd_i.commit && rec_we) || cmd_i.wake;
  assign wr_own  = cmd_i.wake ? wait_q : new_own;
  assign wr_head = cmd_i.wake ? ptr_next(head_q) : new_head;
  assign wr_cnt  = cmd_i.wake ? (cnt_q - CntW'(1)) : new_cnt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      unlock_q <= (mode_i == mbfh_pkg::MODE_UNLOCK);
      mid_q    <= in_mid;
      task_q   <= task_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      own_q  <= own_mem[in_mid];
      head_q <= head_mem[in_mid];
      tail_q <= tail_mem[in_mid];
      cnt_q  <= cnt_mem[in_mid];
    end
    if (rec_wr) begin
      own_mem[mid_q]  <= wr_own;
      head_mem[mid_q] <= wr_head;
      tail_mem[mid_q] <= new_tail;
      cnt_mem[mid_q]  <= wr_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      wait_q <= wait_mem[slot_addr(mid_q, head_q)];
    end
    if (cmd_i.commit && wait_we) begin
      wait_mem[slot_addr(mid_q, tail_q)] <= task_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (cmd_i.commit && held_we) begin
      held_q[mid_q] <= held_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wake) begin
      status_q      <= mbfh_pkg::ST_HANDOFF;
      woken_task_q  <= wait_q;
      woken_valid_q <= 1'b1;
    end else if (cmd_i.commit) begin
      status_q      <= dec_status;
      woken_task_q  <= '0;
      woken_valid_q <= 1'b0;
    end
  end

  assign status_o      = status_q;
  assign woken_task_o  = woken_task_q;
  assign woken_valid_o = woken_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/mbfh_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbfh_ctrl
// request sequencer: accept, evaluate, optional waiter read, result handshake
// ----------------------------------------------------------------------------
`default_nettype none

`include "mutex_bank_with_fifo_handoff_assert.svh"

module mbfh_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  input  wire  mbfh_pkg::sts_t sts_i,
  output mbfh_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StEval = 2'd1;
  localparam logic [1:0] StWake = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       slot_free;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = in_fire;
    state_d       = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StEval;
        end
      end
      StEval: begin
        if (sts_i.handoff) begin
          cmd_o.pop = 1'b1;
          state_d   = StWake;
        end else if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      StWake: begin
        if (slot_free) begin
          cmd_o.wake = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit || cmd_o.wake) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `MBFH_ASSERT_NEXT(a_accept_to_eval, clk_i, rst_ni, in_fire, (state_q == StEval), "accepted beat did not enter evaluation")
  `MBFH_ASSERT_NEXT(a_pop_to_wake, clk_i, rst_ni, cmd_o.pop, (state_q == StWake), "waiter read not followed by handoff")
  `MBFH_ASSERT_NOW(a_cmd_exclusive, clk_i, rst_ni, 1'b1, ($onehot0({cmd_o.capture, cmd_o.commit, cmd_o.pop, cmd_o.wake})), "more than one datapath command at once")
  `MBFH_ASSERT_NEXT(a_result_shown, clk_i, rst_ni, (cmd_o.commit || cmd_o.wake), out_valid_q, "loaded result not presented")

endmodule

`default_nettype wire
